@@ sv/hth_pkg.sv @@
// Shared constants, types and controller/datapath interface for the hit time histogram.
// No dependencies; imported by hth_ctrl, hth_dpath, the top level and the testbench.
package hth_pkg;

  localparam int unsigned HIT_DEPTH = 1024;
  localparam int unsigned HIST_BINS = 64;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned RES_W     = 20;
  localparam int unsigned BCOUNT_W  = 11;
  localparam int unsigned HIT_AW    = $clog2(HIT_DEPTH);
  localparam int unsigned HCNT_W    = $clog2(HIT_DEPTH + 1);
  localparam int unsigned BIN_W     = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
  localparam int unsigned REM_W     = RES_W + BIN_W;
  localparam int unsigned STEP_W    = $clog2(BIN_W + 1);

  localparam logic [RES_W-1:0]    RES_RESET      = RES_W'(1000);
  localparam logic [BCOUNT_W-1:0] BCOUNT_MAX     = '1;
  localparam logic [TIME_W-1:0]   EARLIEST_RESET = {1'b0, {(TIME_W-1){1'b1}}};

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BIN_RD,
    ST_BIN_OFS,
    ST_BIN_CHK,
    ST_BIN_DIV,
    ST_BIN_CRD,
    ST_BIN_CWR,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic hit_load;    // accepted input hit
    logic bin_init;    // restart hit walk
    logic hit_rd;      // read hit store at walk index
    logic ofs_ld;      // register offset from earliest
    logic chk;         // range check, seed divider
    logic div_step;    // one quotient bit
    logic cnt_rd;      // read bin count at quotient
    logic cnt_wr;      // write back incremented count
    logic idx_inc;     // next stored hit
    logic emit_init;   // emission index to bin 0
    logic emit_rd;     // read bin count at emission index
    logic out_ld;      // load output register
    logic emit_inc;    // next bin
    logic clear;       // end of burst
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bin_ovf;     // offset past last bin
    logic div_done;    // final quotient bit this cycle
    logic idx_last;    // walk index at last stored hit
    logic emit_last;   // emission index at highest bin
  } sts_t;

endpackage

@@ sv/hth_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module hth_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/hth_ctrl.sv @@
// Sequencing controller: load, per-hit binning walk and bin emission.
// Depends on hth_pkg.
module hth_ctrl import hth_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic last_hit_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.hit_load = 1'b1;
          if (last_hit_i) begin
            cmd_o.bin_init = 1'b1;
            state_d        = ST_BIN_RD;
          end
        end
      end
      ST_BIN_RD: begin
        cmd_o.hit_rd = 1'b1;
        state_d      = ST_BIN_OFS;
      end
      ST_BIN_OFS: begin
        cmd_o.ofs_ld = 1'b1;
        state_d      = ST_BIN_CHK;
      end
      ST_BIN_CHK: begin
        cmd_o.chk = 1'b1;
        if (!sts_i.bin_ovf) begin
          state_d = ST_BIN_DIV;
        end else if (sts_i.idx_last) begin
          cmd_o.emit_init = 1'b1;
          state_d         = ST_EMIT_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_BIN_RD;
        end
      end
      ST_BIN_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_BIN_CRD;
        end
      end
      ST_BIN_CRD: begin
        cmd_o.cnt_rd = 1'b1;
        state_d      = ST_BIN_CWR;
      end
      ST_BIN_CWR: begin
        cmd_o.cnt_wr = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.emit_init = 1'b1;
          state_d         = ST_EMIT_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_BIN_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd_o.out_ld = 1'b1;
        state_d      = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (sts_i.emit_last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
          end else begin
            cmd_o.emit_inc = 1'b1;
            state_d        = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

@@ sv/hth_dpath.sv @@
// Datapath: hit store, earliest tracking, offset, bit-serial binning divider,
// bin count store with valid bits, output register. Depends on hth_pkg and hth_ram.
module hth_dpath import hth_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RES_W-1:0]    cfg_wdata_i,
  input  logic [TIME_W-1:0]   hit_time_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic [BCOUNT_W-1:0] bin_count_o,
  output logic                last_bin_o,
  output logic                hits_dropped_o,
  output logic                bin_overflow_o
);

  logic [RES_W-1:0]     res_q;
  logic [HCNT_W-1:0]    hit_cnt_q;
  logic [TIME_W-1:0]    earliest_q;
  logic [BIN_W-1:0]     highest_q;
  logic                 drop_q;
  logic                 ovf_q;
  logic [HIST_BINS-1:0] bvalid_q;
  logic                 rd_vld_q;

  logic [HIT_AW-1:0]    idx_q;
  logic [TIME_W-1:0]    ofs_q;
  logic [REM_W-1:0]     rem_q;
  logic [REM_W-1:0]     dvs_q;
  logic [BIN_W-1:0]     quo_q;
  logic [STEP_W-1:0]    step_q;
  logic [BIN_W-1:0]     emit_idx_q;

  logic [BCOUNT_W-1:0]  bcount_q;
  logic                 last_bin_q;
  logic                 dropped_q;
  logic                 bovf_q;

  logic                 full;
  logic                 store_hit;
  logic                 earlier;
  logic [TIME_W-1:0]    hit_rdata;
  logic [TIME_W:0]      ofs_ext;
  logic [RES_W-1:0]     res_eff;
  logic [REM_W-1:0]     lim;
  logic                 rem_ge;
  logic [BIN_W-1:0]     cnt_raddr;
  logic [BCOUNT_W-1:0]  cnt_rdata;
  logic [BCOUNT_W-1:0]  cnt_val;
  logic [BCOUNT_W-1:0]  cnt_inc;

  assign full      = (hit_cnt_q == HCNT_W'(HIT_DEPTH));
  assign store_hit = cmd_i.hit_load && !full;
  assign earlier   = $signed(hit_time_i) < $signed(earliest_q);

  hth_ram #(
    .Width (TIME_W),
    .Depth (HIT_DEPTH)
  ) u_hit_ram (
    .clk_i   (clk_i),
    .we_i    (store_hit),
    .waddr_i (hit_cnt_q[HIT_AW-1:0]),
    .wdata_i (hit_time_i),
    .re_i    (cmd_i.hit_rd),
    .raddr_i (idx_q),
    .rdata_o (hit_rdata)
  );

  // offset is never negative and fits 32 bits unsigned
  assign ofs_ext = {hit_rdata[TIME_W-1], hit_rdata} - {earliest_q[TIME_W-1], earliest_q};
  assign res_eff = (res_q == '0) ? RES_W'(1) : res_q;
  assign lim     = REM_W'(res_eff) * REM_W'(HIST_BINS);
  assign rem_ge  = rem_q >= dvs_q;

  assign cnt_raddr = cmd_i.emit_rd ? emit_idx_q : quo_q;

  hth_ram #(
    .Width (BCOUNT_W),
    .Depth (HIST_BINS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.cnt_wr),
    .waddr_i (quo_q),
    .wdata_i (cnt_inc),
    .re_i    (cmd_i.cnt_rd || cmd_i.emit_rd),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  // bins not written this burst read as zero
  assign cnt_val = rd_vld_q ? cnt_rdata : '0;
  assign cnt_inc = (cnt_val == BCOUNT_MAX) ? cnt_val : cnt_val + BCOUNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q      <= RES_RESET;
      hit_cnt_q  <= '0;
      earliest_q <= EARLIEST_RESET;
      highest_q  <= '0;
      drop_q     <= 1'b0;
      ovf_q      <= 1'b0;
      bvalid_q   <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        res_q <= cfg_wdata_i;
      end
      if (cmd_i.hit_load) begin
        if (full) begin
          drop_q <= 1'b1;
        end else begin
          hit_cnt_q <= hit_cnt_q + HCNT_W'(1);
          if (earlier) begin
            earliest_q <= hit_time_i;
          end
        end
      end
      if (cmd_i.chk && (TIME_W'(lim) <= ofs_q)) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.cnt_rd || cmd_i.emit_rd) begin
        rd_vld_q <= bvalid_q[cnt_raddr];
      end
      if (cmd_i.cnt_wr) begin
        bvalid_q[quo_q] <= 1'b1;
        if (quo_q > highest_q) begin
          highest_q <= quo_q;
        end
      end
      if (cmd_i.clear) begin
        hit_cnt_q  <= '0;
        earliest_q <= EARLIEST_RESET;
        highest_q  <= '0;
        drop_q     <= 1'b0;
        ovf_q      <= 1'b0;
        bvalid_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bin_init) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + HIT_AW'(1);
    end
    if (cmd_i.ofs_ld) begin
      ofs_q <= ofs_ext[TIME_W-1:0];
    end
    // restoring division, quotient known to fit BIN_W bits
    if (cmd_i.chk) begin
      rem_q  <= REM_W'(ofs_q);
      dvs_q  <= REM_W'(res_eff) << (BIN_W - 1);
      quo_q  <= '0;
      step_q <= STEP_W'(BIN_W - 1);
    end else if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= rem_q - dvs_q;
      end
      quo_q  <= BIN_W'({quo_q, rem_ge});
      dvs_q  <= dvs_q >> 1;
      step_q <= step_q - STEP_W'(1);
    end
    if (cmd_i.emit_init) begin
      emit_idx_q <= '0;
    end else if (cmd_i.emit_inc) begin
      emit_idx_q <= emit_idx_q + BIN_W'(1);
    end
    if (cmd_i.out_ld) begin
      bcount_q   <= cnt_val;
      last_bin_q <= (emit_idx_q == highest_q);
      dropped_q  <= drop_q;
      bovf_q     <= ovf_q;
    end
  end

  assign sts_o.bin_ovf   = TIME_W'(lim) <= ofs_q;
  assign sts_o.div_done  = (step_q == '0);
  assign sts_o.idx_last  = ((HCNT_W'(idx_q) + HCNT_W'(1)) == hit_cnt_q);
  assign sts_o.emit_last = (emit_idx_q == highest_q);

  assign bin_count_o    = bcount_q;
  assign last_bin_o     = last_bin_q;
  assign hits_dropped_o = dropped_q;
  assign bin_overflow_o = bovf_q;

endmodule

@@ sv/hit_time_histogram_unit.sv @@
// Hit time histogram: usage notes.
// Input channel (in_valid_i / in_stall_o) takes one hit per transaction: hit_time_i
// (signed ps) and last_hit_i. Hits load one per cycle into a 1024-entry hit store while
// the earliest time is tracked. Hits past the store depth are dropped and flagged.
// A transaction with last_hit_i set stores its hit, then the block stalls input while it
// walks the stored hits: each hit goes through read, offset and range check; one that
// lands past the last bin ends there, otherwise the bit-serial quotient loop finds its
// bin and the bin count takes a read-modify-write.
// Output channel (out_valid_o / out_stall_i) then delivers bins 0 through the highest
// occupied bin, one transaction each; each bin goes through count read, output load and
// handover before the next is read. last_bin_o marks the final bin; hits_dropped_o and
// bin_overflow_o are constant over a burst. While the receiver stalls, the output holds and
// the block waits. After the final bin the burst state clears and input is taken again.
// Reset (rst_ni low, asynchronous) empties the store, clears the histogram and sets
// resolution to 1000 ps; no clearing pass is needed.
// cfg_we_i / cfg_wdata_i write the bin resolution; write only while idle.
// Depends on hth_pkg, hth_ctrl, hth_dpath, hth_ram.
module hit_time_histogram_unit import hth_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RES_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [TIME_W-1:0]   hit_time_i,
  input  logic                last_hit_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [BCOUNT_W-1:0] bin_count_o,
  output logic                last_bin_o,
  output logic                hits_dropped_o,
  output logic                bin_overflow_o
);

  cmd_t cmd;
  sts_t sts;

  hth_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .last_hit_i  (last_hit_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hth_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .hit_time_i     (hit_time_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .bin_count_o    (bin_count_o),
    .last_bin_o     (last_bin_o),
    .hits_dropped_o (hits_dropped_o),
    .bin_overflow_o (bin_overflow_o)
  );

endmodule

@@ tb/hit_time_histogram_unit_test.sv @@
// Self-checking testbench for hit_time_histogram_unit: directed and random hit bursts,
// checked bin by bin against a behavioral histogram predictor. Depends on hth_pkg.
`timescale 1ns / 1ps

module hit_time_histogram_unit_test;
  import hth_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned SETTLE_TICKS = 12;

  typedef struct {
    logic [BCOUNT_W-1:0] count;
    logic                last;
    logic                dropped;
    logic                ovf;
  } bin_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [RES_W-1:0]    cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [TIME_W-1:0]   hit_time_i;
  logic                last_hit_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [BCOUNT_W-1:0] bin_count_o;
  logic                last_bin_o;
  logic                hits_dropped_o;
  logic                bin_overflow_o;

  // histogram predictor state
  int                  hits_held [HIT_DEPTH];
  int unsigned         stored_hits;
  longint              earliest_ps;
  logic [BCOUNT_W-1:0] bin_tally [HIST_BINS];
  int unsigned         top_bin;
  bit                  burst_dropped;
  logic [RES_W-1:0]    res_setting;

  bin_result_t bins_due[$];

  bit          idle_on;
  int unsigned stall_left;
  int unsigned cycle_count;
  int unsigned errors;
  int unsigned hits_sent;
  int unsigned bursts_done;
  int unsigned bins_checked;
  int unsigned res_writes;

  hit_time_histogram_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .hit_time_i     (hit_time_i),
    .last_hit_i     (last_hit_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bin_count_o    (bin_count_o),
    .last_bin_o     (last_bin_o),
    .hits_dropped_o (hits_dropped_o),
    .bin_overflow_o (bin_overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_histogram();
    stored_hits   = 0;
    earliest_ps   = 64'sd2147483647;
    top_bin       = 0;
    burst_dropped = 1'b0;
    foreach (bin_tally[b]) bin_tally[b] = '0;
  endfunction

  // Store one hit; on the last hit of a burst, bin everything and queue the bin counts.
  function automatic void histogram_hit(logic [TIME_W-1:0] t, logic last);
    longint           offs;
    longint           bin;
    longint           width;
    bit               ovf;
    bin_result_t      r;
    ovf = 1'b0;
    if (stored_hits < HIT_DEPTH) begin
      hits_held[stored_hits] = $signed(t);
      stored_hits++;
      if (longint'($signed(t)) < earliest_ps) earliest_ps = longint'($signed(t));
    end else begin
      burst_dropped = 1'b1;
    end
    if (!last) return;
    width = (res_setting == '0) ? 64'sd1 : longint'(res_setting);
    for (int i = 0; i < stored_hits; i++) begin
      offs = longint'(hits_held[i]) - earliest_ps;
      bin  = offs / width;
      if (bin < HIST_BINS) begin
        if (bin_tally[bin] != BCOUNT_MAX) bin_tally[bin]++;
        if (bin > top_bin) top_bin = 32'(bin);
      end else begin
        ovf = 1'b1;
      end
    end
    for (int i = 0; i <= top_bin; i++) begin
      r.count   = bin_tally[i];
      r.last    = (i == top_bin);
      r.dropped = burst_dropped;
      r.ovf     = ovf;
      bins_due.push_back(r);
    end
    bursts_done++;
    clear_histogram();
  endfunction

  // One input transaction; valid stays high afterwards unless a gap follows.
  task automatic send_hit(input logic [TIME_W-1:0] t, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    hit_time_i <= t;
    last_hit_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    histogram_hit(t, last);
    hits_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic set_resolution(input logic [RES_W-1:0] r);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    res_setting = r;
    cfg_we_i <= 1'b0;
    res_writes++;
  endtask

  // Hit near the burst base, now and then earlier, near or past the last bin, or anywhere.
  function automatic logic [TIME_W-1:0] pick_hit(logic [TIME_W-1:0] base);
    int unsigned span;
    span = (res_setting == '0) ? 1 : res_setting;
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return base - $urandom_range(0, span * 4);
      2:       return base + $urandom_range(span * 60, span * 70);
      default: return base + $urandom_range(0, span * 64);
    endcase
  endfunction

  function automatic logic [RES_W-1:0] pick_resolution();
    case ($urandom_range(0, 5))
      0:       return RES_W'(1);
      1:       return '1;
      2:       return '0;
      3:       return RES_W'($urandom_range(1, 4095));
      default: return RES_W'($urandom_range(1, (1 << RES_W) - 1));
    endcase
  endfunction

  // reset value of the resolution register
  task automatic test_basic_bursts();
    send_hit(32'd0, 1'b0);
    send_hit(32'd999, 1'b0);
    send_hit(32'd1000, 1'b0);
    send_hit(32'd2500, 1'b0);
    send_hit(32'd63999, 1'b0);
    send_hit(32'd64000, 1'b1);   // one past the last bin
  endtask

  task automatic test_time_extremes();
    send_hit(32'h7FFF_FFFF, 1'b0);
    send_hit(32'h8000_0000, 1'b1);   // widest possible offset
    send_hit(32'h8000_0000, 1'b1);
    send_hit(32'h7FFF_FFFF, 1'b1);
    send_hit(32'hFFFF_FFFF, 1'b0);
    send_hit(32'h0000_0000, 1'b1);
  endtask

  task automatic test_resolution_extremes();
    set_resolution(RES_W'(1));
    send_hit(32'd100, 1'b0);
    send_hit(32'd100, 1'b0);
    send_hit(32'd163, 1'b0);
    send_hit(32'd164, 1'b1);
    set_resolution('1);
    send_hit(32'd0, 1'b0);
    send_hit(32'd1048574, 1'b0);
    send_hit(32'd1048575, 1'b0);
    send_hit(32'd66060225, 1'b0);
    send_hit(32'd67108800, 1'b1);
    set_resolution('0);          // zero width acts as one
    send_hit(32'd10, 1'b0);
    send_hit(32'd11, 1'b0);
    send_hit(32'd12, 1'b1);
  endtask

  task automatic test_random_bursts(input int unsigned n_hits, input bit with_idle);
    logic [TIME_W-1:0] base;
    int unsigned       len;
    int unsigned       sent;
    sent = 0;
    while (sent < n_hits) begin
      if ($urandom_range(0, 2) == 0) set_resolution(pick_resolution());
      if (with_idle) idle_on = ($urandom_range(0, 4) != 0);
      base = $urandom;
      len  = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) send_hit(pick_hit(base), i == len - 1);
      sent += len;
    end
  endtask

  // output stall bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) stall_left--;
    else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 14);
    out_stall_i <= (stall_left != 0);
  end

  always @(posedge clk_i) begin : check_bins
    bin_result_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bins_due.size() == 0) begin
        $error("unexpected bin transaction: bin_count %0d", bin_count_o);
        errors++;
      end else begin
        exp = bins_due.pop_front();
        bins_checked++;
        if (bin_count_o !== exp.count) begin
          $error("bin_count: expected %0d, got %0d", exp.count, bin_count_o);
          errors++;
        end
        if (last_bin_o !== exp.last) begin
          $error("last_bin: expected %0b, got %0b", exp.last, last_bin_o);
          errors++;
        end
        if (hits_dropped_o !== exp.dropped) begin
          $error("hits_dropped: expected %0b, got %0b", exp.dropped, hits_dropped_o);
          errors++;
        end
        if (bin_overflow_o !== exp.ovf) begin
          $error("bin_overflow: expected %0b, got %0b", exp.ovf, bin_overflow_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bins outstanding", cycle_count, bins_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    hit_time_i  <= '0;
    last_hit_i  <= 1'b0;
    out_stall_i <= 1'b0;
    idle_on      = 1'b1;
    stall_left   = 0;
    cycle_count  = 0;
    errors       = 0;
    hits_sent    = 0;
    bursts_done  = 0;
    bins_checked = 0;
    res_writes   = 0;
    res_setting  = RES_RESET;
    clear_histogram();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_bursts();
    test_time_extremes();
    test_resolution_extremes();
    test_random_bursts(150, 1'b1);
    idle_on = 1'b0;
    test_random_bursts(40, 1'b0);
    drain();

    $display("Sent %0d hits in %0d bursts over %0d resolution writes; %0d bins checked",
             hits_sent, bursts_done, res_writes, bins_checked);
    $display("Included out-of-range bins, extreme hit times and zero/max resolution");
    if (errors == 0 && bins_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/hth_pkg.sv
sv/hth_ram.sv
sv/hth_ctrl.sv
sv/hth_dpath.sv
sv/hit_time_histogram_unit.sv
tb/hit_time_histogram_unit_test.sv
